[rtl/block_bitmap_allocator_unit_assert.svh]
// assertion macros used by the checker file bba_checker.sv
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bba check failed");

// next-cycle implication, disabled while reset is high
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bba check failed");

`endif

[rtl/bba_pkg.sv]
package bba_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int BLK_W     = 12;
   localparam int CNT_W     = 7;

   localparam logic [1:0] OP_MARK_USED = 2'd0;
   localparam logic [1:0] OP_MARK_FREE = 2'd1;
   localparam logic [1:0] OP_FIND      = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic                 any;
      logic [BIT_W-1:0]     idx;
      logic [WORD_BITS-1:0] rest;
   } pick_type;

endpackage

[rtl/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bba_pick.sv]
module bba_pick (
   input  logic [bba_pkg::WORD_BITS-1:0] mask,
   output bba_pkg::pick_type             pick
);

   logic [bba_pkg::BIT_W-1:0] idx;

   // lowest free bit of the word
   always_comb begin
      idx = '0;
      for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = bba_pkg::BIT_W'(i);
         end
      end
   end

   assign pick.any  = |mask;
   assign pick.idx  = idx;
   assign pick.rest = mask & (mask - bba_pkg::WORD_BITS'(1));

endmodule

[rtl/block_bitmap_allocator_unit.sv]
// channel   ports                                            handshake
// request   req_opcode, req_block_index, req_count           start && !busy
// result    rsp_found_block, rsp_status, rsp_last            rsp_valid, one cycle
// config    csr_wdata                                        csr_write_en
// mark: the map word is read, then written back; clear: map words are zeroed one a cycle
// find: each word goes S_SCAN_LD then S_SCAN_PICK, one free block per cycle, then S_EMIT;
// the single-port-read map memory, one 64-bit word per read, sets the scan time
// after reset the map is swept to zero, one word a cycle, busy high meanwhile
// results cannot be stalled; multi-block results come on consecutive cycles
module block_bitmap_allocator_unit #(
   parameter int NUM_BLOCKS  = 4096,
   parameter int MAX_REQUEST = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [bba_pkg::BLK_W-1:0]    req_block_index,
   input  logic [bba_pkg::CNT_W-1:0]    req_count,
   output logic                         rsp_valid,
   output logic [bba_pkg::BLK_W-1:0]    rsp_found_block,
   output logic                         rsp_status,
   output logic                         rsp_last,
   input  logic                         csr_write_en,
   input  logic [bba_pkg::BLK_W-1:0]    csr_wdata
);

   localparam int WB        = bba_pkg::WORD_BITS;
   localparam int BW        = bba_pkg::BIT_W;
   localparam int MAP_WORDS = (NUM_BLOCKS + WB - 1) / WB;
   localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int FAW       = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
   localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WB;
   localparam logic [WB-1:0]  LAST_MASK = {WB{1'b1}} >> (WB - LAST_BITS);
   localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);
   localparam logic [bba_pkg::CNT_W-1:0] MAX_WANT = bba_pkg::CNT_W'(MAX_REQUEST);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_MARK      = 3'd2;
   localparam logic [2:0] S_SCAN_LD   = 3'd3;
   localparam logic [2:0] S_SCAN_PICK = 3'd4;
   localparam logic [2:0] S_EMIT      = 3'd5;
   localparam logic [2:0] S_DRAIN     = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic [bba_pkg::BLK_W-1:0]   blk_ff, blk_in;
   logic [bba_pkg::CNT_W-1:0]   want_ff, want_in;
   logic [WAW-1:0]              word_ff, word_in;
   logic                        first_ff, first_in;
   logic [WB-1:0]               mask_ff, mask_in;
   logic [bba_pkg::CNT_W-1:0]   got_ff, got_in;
   logic [bba_pkg::CNT_W-1:0]   emit_ff, emit_in;
   logic                        emit_rd_ff, emit_rd_in;
   logic                        emit_last_ff, emit_last_in;
   logic [bba_pkg::BLK_W-1:0]   fub_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::BLK_W-1:0]   rsp_found_ff, rsp_found_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        map_we;
   logic [WAW-1:0]              map_waddr, map_raddr;
   logic [WB-1:0]               map_wdata, map_rdata;
   logic                        fl_we;
   logic [FAW-1:0]              fl_waddr, fl_raddr;
   logic [bba_pkg::BLK_W-1:0]   fl_wdata, fl_rdata;

   bba_pkg::pick_type           pick;
   logic [31:0]                 req_blk_wide, blk_wide, fub_wide, pos_wide;
   logic [WAW-1:0]              req_word, blk_word, fub_word;
   logic [WB-1:0]               bit_sel, start_mask, tail_mask;
   logic                        blk_in_range, fub_beyond;
   logic [bba_pkg::CNT_W-1:0]   req_want, got_nxt, emit_nxt;

   bba_ram #(.WIDTH(WB), .DEPTH(MAP_WORDS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   bba_ram #(.WIDTH(bba_pkg::BLK_W), .DEPTH(MAX_REQUEST)) u_found (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_addr (fl_raddr),
      .rd_data (fl_rdata)
   );

   bba_pick u_pick (
      .mask (mask_ff),
      .pick (pick)
   );

   assign req_blk_wide = 32'(req_block_index);
   assign blk_wide     = 32'(blk_ff);
   assign fub_wide     = 32'(fub_ff);
   assign req_word     = req_blk_wide[BW +: WAW];
   assign blk_word     = blk_wide[BW +: WAW];
   assign fub_word     = fub_wide[BW +: WAW];
   assign blk_in_range = blk_wide < 32'(NUM_BLOCKS);
   assign fub_beyond   = fub_wide >= 32'(NUM_BLOCKS);
   assign bit_sel      = WB'(1) << blk_ff[BW-1:0];
   assign start_mask   = first_ff ? ({WB{1'b1}} << fub_ff[BW-1:0]) : {WB{1'b1}};
   assign tail_mask    = (word_ff == LAST_WORD) ? LAST_MASK : {WB{1'b1}};
   assign pos_wide     = 32'({word_ff, pick.idx});
   assign got_nxt      = got_ff + bba_pkg::CNT_W'(1);
   assign emit_nxt     = emit_ff + bba_pkg::CNT_W'(1);

   always_comb begin
      if (req_count == '0) begin
         req_want = bba_pkg::CNT_W'(1);
      end else if (req_count > MAX_WANT) begin
         req_want = MAX_WANT;
      end else begin
         req_want = req_count;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      want_in       = want_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      mask_in       = mask_ff;
      got_in        = got_ff;
      emit_in       = emit_ff;
      emit_rd_in    = 1'b0;
      emit_last_in  = emit_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_wdata     = '0;
      map_raddr     = word_ff;
      fl_we         = 1'b0;
      fl_waddr      = got_ff[FAW-1:0];
      fl_wdata      = pos_wide[bba_pkg::BLK_W-1:0];
      fl_raddr      = emit_ff[FAW-1:0];

      // found list read data lands in the cycle after the read
      if (emit_rd_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = fl_rdata;
         rsp_status_in = bba_pkg::STATUS_DONE;
         rsp_last_in   = emit_last_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = word_ff;
            map_wdata = '0;
            if (word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WAW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               case (req_opcode)
                  bba_pkg::OP_MARK_USED, bba_pkg::OP_MARK_FREE: begin
                     op_in     = req_opcode;
                     blk_in    = req_block_index;
                     map_raddr = req_word;
                     state_in  = S_MARK;
                  end
                  bba_pkg::OP_FIND: begin
                     want_in = req_want;
                     if (fub_beyond) begin
                        rsp_valid_in  = 1'b1;
                        rsp_found_in  = '0;
                        rsp_status_in = bba_pkg::STATUS_SHORT;
                        rsp_last_in   = 1'b1;
                     end else begin
                        word_in   = fub_word;
                        map_raddr = fub_word;
                        first_in  = 1'b1;
                        got_in    = '0;
                        state_in  = S_SCAN_LD;
                     end
                  end
                  bba_pkg::OP_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     rsp_found_in  = '0;
                     rsp_status_in = bba_pkg::STATUS_DONE;
                     rsp_last_in   = 1'b1;
                     word_in       = '0;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MARK: begin
            map_we    = blk_in_range;
            map_waddr = blk_word;
            map_wdata = (op_ff == bba_pkg::OP_MARK_USED) ? (map_rdata | bit_sel)
                                                          : (map_rdata & ~bit_sel);
            rsp_valid_in  = 1'b1;
            rsp_found_in  = blk_ff;
            rsp_status_in = bba_pkg::STATUS_DONE;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN_LD: begin
            mask_in  = ~map_rdata & start_mask & tail_mask;
            first_in = 1'b0;
            state_in = S_SCAN_PICK;
         end
         S_SCAN_PICK: begin
            if (!pick.any) begin
               if (word_ff == LAST_WORD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = '0;
                  rsp_status_in = bba_pkg::STATUS_SHORT;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  word_in   = word_ff + WAW'(1);
                  map_raddr = word_ff + WAW'(1);
                  state_in  = S_SCAN_LD;
               end
            end else begin
               fl_we   = 1'b1;
               mask_in = pick.rest;
               got_in  = got_nxt;
               if (got_nxt == want_ff) begin
                  emit_in  = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            fl_raddr     = emit_ff[FAW-1:0];
            emit_rd_in   = 1'b1;
            emit_last_in = (emit_nxt == got_ff);
            emit_in      = emit_nxt;
            if (emit_nxt == got_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         first_ff     <= 1'b0;
         got_ff       <= '0;
         emit_ff      <= '0;
         emit_rd_ff   <= 1'b0;
         emit_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fub_ff       <= bba_pkg::BLK_W'(1);
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         first_ff     <= first_in;
         got_ff       <= got_in;
         emit_ff      <= emit_in;
         emit_rd_ff   <= emit_rd_in;
         emit_last_ff <= emit_last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            fub_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      want_ff       <= want_in;
      mask_ff       <= mask_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_block = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[rtl/bba_checker.sv]
`include "block_bitmap_allocator_unit_assert.svh"

module bba_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [bba_pkg::BLK_W-1:0] rsp_found_block,
   input logic                      rsp_status,
   input logic                      rsp_last
);

   // a multi-block answer streams without gaps
   `BBA_ASSERT_NEXT(a_stream_gapless, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   // more results pending means the unit is still working
   `BBA_ASSERT_NOW(a_pending_busy, clock, reset, rsp_valid && !rsp_last, busy)
   // a short answer is a single final result
   `BBA_ASSERT_NOW(a_short_last, clock, reset, rsp_valid && rsp_status, rsp_last)
   // a short answer carries no block
   `BBA_ASSERT_NOW(a_short_zero, clock, reset, rsp_valid && rsp_status, rsp_found_block == '0)

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_found_block (rsp_found_block),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
